/* rtl/awt_pkg.sv */
// ----------------------------------------------------------------------------
// Address whitelist table package
// Shared widths, defaults and operation codes for the whitelist table.
// ----------------------------------------------------------------------------
package awt_pkg;

    localparam int DEFAULT_MAX_ENTRIES   = 64;
    localparam int DEFAULT_ADDRESS_BYTES = 8;

    localparam int FUNC_W        = 2;
    localparam int DEVICE_ID_W   = 64;
    localparam int ENTRY_COUNT_W = 7;
    // was_listed, success, entry_count padded to whole bytes
    localparam int M_FIELDS_W    = 2 + ENTRY_COUNT_W;
    localparam int M_TDATA_W     = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t OP_CHECK  = 2'd0;
    localparam func_t OP_ADD    = 2'd1;
    localparam func_t OP_REMOVE = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_ACT   = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

/* rtl/awt_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module awt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/address_whitelist_table_unit.sv */
// ----------------------------------------------------------------------------
// Address whitelist table unit
// Packed table of device addresses with check, add and remove requests.
// ----------------------------------------------------------------------------
// Sequence: a check or add scans from slot zero until the address is found or
// every listed entry has been read, then returns its result; a remove of a
// listed address also shifts every later entry down one slot to close the gap.
// Throughput: one request at a time; the single RAM read port walks one entry
// per cycle in both the scan and the shift.
// Reset: aresetn (synchronous) empties the table at once; no clearing pass.
module address_whitelist_table_unit #(
    parameter int MAX_ENTRIES   = awt_pkg::DEFAULT_MAX_ENTRIES,
    parameter int ADDRESS_BYTES = awt_pkg::DEFAULT_ADDRESS_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [awt_pkg::DEVICE_ID_W-1:0] s_tdata,   // [63:0] device_id
    input  logic [awt_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [awt_pkg::M_TDATA_W-1:0]   m_tdata    // [0] was_listed,
                                                       // [1] success,
                                                       // [8:2] entry_count,
                                                       // [15:9] zero
);
    import awt_pkg::*;

    localparam int KEY_W  = 8 * ADDRESS_BYTES;
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int PAD_W  = M_TDATA_W - M_FIELDS_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    // sequencer state
    state_t             state_reg,   state_next;
    func_t              op_reg,      op_next;
    logic [KEY_W-1:0]   key_reg,     key_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [CNT_W-1:0]   idx_reg,     idx_next;
    logic               pend_reg,    pend_next;
    logic [ADDR_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic               found_reg,   found_next;
    logic [ADDR_W-1:0]  slot_reg,    slot_next;
    logic               ok_reg,      ok_next;

    // output register
    logic                     m_valid_reg,    m_valid_next;
    logic                     out_listed_reg;
    logic                     out_ok_reg;
    logic [ENTRY_COUNT_W-1:0] out_count_reg;
    logic                     out_load;
    logic [CNT_W+ENTRY_COUNT_W-1:0] count_ext;

    // table memory
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;
    logic              hit;

    awt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_count_reg, out_ok_reg, out_listed_reg};

    // Read data from the previous cycle matches the key under search
    assign hit = pend_reg && (ram_rdata == key_reg);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pend_next    = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        found_next   = found_reg;
        slot_next    = slot_reg;
        ok_next      = ok_reg;
        ram_we       = 1'b0;
        ram_waddr    = count_reg[ADDR_W-1:0];
        ram_wdata    = key_reg;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg[ADDR_W-1:0];
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                // Capture the request and start the scan at slot zero
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[KEY_W-1:0];
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle; compare the entry read last cycle
                if (hit) begin
                    found_next = 1'b1;
                    slot_next  = cmp_idx_reg;
                    state_next = ST_ACT;
                end else if (idx_reg < count_reg) begin
                    ram_re       = 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    found_next = 1'b0;
                    state_next = ST_ACT;
                end
            end
            ST_ACT: begin
                state_next = ST_DONE;
                case (op_reg)
                    OP_ADD: begin
                        if (found_reg) begin
                            ok_next = 1'b1;
                        end else if (count_reg < MAX_CNT) begin
                            // Append at the end of the packed table
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            ok_next    = 1'b1;
                        end else begin
                            ok_next = 1'b0;
                        end
                    end
                    OP_REMOVE: begin
                        ok_next = 1'b1;
                        if (found_reg) begin
                            idx_next   = CNT_W'(slot_reg) + 1'b1;
                            state_next = ST_SHIFT;
                        end
                    end
                    default: begin
                        ok_next = found_reg;
                    end
                endcase
            end
            ST_SHIFT: begin
                // Read entry i and write it back to i-1 in the following cycle
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = cmp_idx_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (idx_reg < count_reg) begin
                    ram_re       = 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Mask the count down to the result field width
    assign count_ext = (CNT_W + ENTRY_COUNT_W)'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        ok_reg      <= ok_next;
        if (out_load) begin
            out_listed_reg <= found_reg;
            out_ok_reg     <= ok_reg;
            out_count_reg  <= count_ext[ENTRY_COUNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("entry count exceeds table size");

    a_shift_only_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (op_reg == OP_REMOVE) && found_reg)
        else $error("shift entered without a listed remove");

    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ACT && state_reg != ST_SHIFT) |=> $stable(count_reg))
        else $error("entry count changed outside update states");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("pending result overwritten");

endmodule

/* tb/address_whitelist_table_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address whitelist table unit testbench
// Drives check, add, remove and unused-code requests over the request stream.
// A shadow copy of the table predicts each result, and every result
// transaction is compared with the oldest prediction. Both sides idle at
// random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module address_whitelist_table_unit_tb;

    import awt_pkg::*;

    localparam int    MAX_ENTRIES   = DEFAULT_MAX_ENTRIES;
    localparam int    ADDRESS_BYTES = DEFAULT_ADDRESS_BYTES;
    // the code left over in the two-bit field behaves as a check
    localparam func_t OP_UNUSED     = 2'd3;
    // covers the worst-case request latency of the block, plus margin
    localparam int    SETTLE_CYCLES = 2 * MAX_ENTRIES + 16;
    localparam int    RANDOM_ITEMS  = 300;

    // result fields, packed so that bit 0 lines up with m_tdata[0]
    typedef struct packed {
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     success;
        logic                     was_listed;
    } outcome_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DEVICE_ID_W-1:0] s_tdata;   // [63:0] device_id
    logic [FUNC_W-1:0]      s_tuser;   // [1:0] func
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // [0] was_listed, [1] success,
                                       // [8:2] entry_count, [15:9] zero

    // shadow copy of the table: listed ids in slots 0..listed_total-1
    logic [DEVICE_ID_W-1:0] listed_ids [MAX_ENTRIES];
    int                     listed_total = 0;
    // every id ever sent, for requests that hit removed or absent entries
    logic [DEVICE_ID_W-1:0] seen_ids [$];
    outcome_t               pending_outcomes [$];
    int                     mismatches  = 0;
    bit                     steady_flow = 1'b0;

    address_whitelist_table_unit #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin : clock_gen
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one request to the shadow table and return the result it causes.
    function automatic outcome_t apply_request(func_t op, logic [DEVICE_ID_W-1:0] id);
        logic [DEVICE_ID_W-1:0] key;
        int                     slot;
        logic                   listed;
        logic                   ok;
        outcome_t               res;
        // only the low ADDRESS_BYTES bytes take part in storing and matching
        key = (ADDRESS_BYTES >= 8) ? id : id & ((64'd1 << (8 * ADDRESS_BYTES)) - 64'd1);
        slot = listed_total;
        for (int i = listed_total - 1; i >= 0; i--) begin
            if (listed_ids[i] == key) begin
                slot = i;
            end
        end
        listed = (slot < listed_total);
        if (op == OP_ADD) begin
            // a duplicate passes untouched; a full table refuses a new id
            if (listed) begin
                ok = 1'b1;
            end else if (listed_total >= MAX_ENTRIES) begin
                ok = 1'b0;
            end else begin
                listed_ids[listed_total] = key;
                listed_total++;
                ok = 1'b1;
            end
        end else if (op == OP_REMOVE) begin
            // close the gap by moving every later entry down one slot
            if (listed) begin
                for (int i = slot; i + 1 < listed_total; i++) begin
                    listed_ids[i] = listed_ids[i + 1];
                end
                listed_total--;
            end
            ok = 1'b1;
        end else begin
            ok = listed;
        end
        res.was_listed  = listed;
        res.success     = ok;
        res.entry_count = listed_total[ENTRY_COUNT_W-1:0];
        return res;
    endfunction

    // Send one request transaction after a random gap (none in steady flow); predict on acceptance.
    task automatic send_request(input func_t op, input logic [DEVICE_ID_W-1:0] id);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        // lower valid only when a gap follows, so it never drops and rises in one step
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_outcomes.push_back(apply_request(op, id));
        seen_ids.push_back(id);
    endtask

    // Hold the request side idle until every predicted result has arrived.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    // Draw an id: mostly listed ones, some seen before, the rest fresh.
    function automatic logic [DEVICE_ID_W-1:0] pick_device_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && listed_total > 0) begin
            return listed_ids[$urandom_range(0, listed_total - 1)];
        end else if (r < 75 && seen_ids.size() > 0) begin
            return seen_ids[$urandom_range(0, seen_ids.size() - 1)];
        end
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed_cases();
        // empty table: nothing listed, remove still succeeds
        send_request(OP_CHECK,  64'h0000_0000_0000_0000);
        send_request(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF);
        // field extremes and alternating patterns
        send_request(OP_ADD,    64'h0000_0000_0000_0000);
        send_request(OP_ADD,    64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_ADD,    64'hAAAA_AAAA_AAAA_AAAA);
        send_request(OP_ADD,    64'h5555_5555_5555_5555);
        send_request(OP_CHECK,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_CHECK,  64'hFFFF_FFFF_FFFF_FFFE);
        // unused code acts as a check, listed and absent
        send_request(OP_UNUSED, 64'h0000_0000_0000_0000);
        send_request(OP_UNUSED, 64'h0123_4567_89AB_CDEF);
        // duplicate add leaves the count alone
        send_request(OP_ADD,    64'h0000_0000_0000_0000);
        // remove of an absent id changes nothing
        send_request(OP_REMOVE, 64'h0123_4567_89AB_CDEF);
        // remove from the middle, then confirm the shift kept the rest
        send_request(OP_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(OP_CHECK,  64'hAAAA_AAAA_AAAA_AAAA);
        send_request(OP_CHECK,  64'h5555_5555_5555_5555);
        // remove the first and the last slot
        send_request(OP_REMOVE, 64'h0000_0000_0000_0000);
        send_request(OP_REMOVE, 64'h5555_5555_5555_5555);
        send_request(OP_CHECK,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_CHECK,  64'hFFFF_FFFF_FFFF_FFFF);
        // pause until the pipeline is empty before the next phase
        wait_results_drained();
    endtask

    task automatic test_fill_to_capacity();
        logic [DEVICE_ID_W-1:0] id;
        // fill back to back for the first half, then with idling
        steady_flow = 1'b1;
        while (listed_total < MAX_ENTRIES) begin
            if (listed_total == MAX_ENTRIES / 2) begin
                steady_flow = 1'b0;
            end
            send_request(OP_ADD, {$urandom, $urandom});
        end
        // a full table refuses a new id but accepts a duplicate
        send_request(OP_ADD,    {$urandom, $urandom});
        send_request(OP_ADD,    listed_ids[MAX_ENTRIES - 1]);
        send_request(OP_CHECK,  listed_ids[0]);
        send_request(OP_UNUSED, listed_ids[MAX_ENTRIES - 1]);
        // longest shift: remove the first slot of a full table
        id = listed_ids[0];
        send_request(OP_REMOVE, id);
        send_request(OP_CHECK,  id);
        send_request(OP_REMOVE, listed_ids[listed_total - 1]);
        send_request(OP_REMOVE, listed_ids[listed_total / 2]);
        // refill to capacity and probe the full edge once more
        while (listed_total < MAX_ENTRIES) begin
            send_request(OP_ADD, {$urandom, $urandom});
        end
        send_request(OP_ADD,    {$urandom, $urandom});
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        func_t op;
        int    r;
        bit    adding_phase;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // switch between growing and shrinking the table every 50 items
            if (n % 50 == 0) begin
                adding_phase = ((n / 50) % 2 == 0) ? 1'b0 : 1'b1;
                steady_flow  = ($urandom_range(0, 3) == 0);
            end
            // one pause mid-run until every result is back
            if (n == RANDOM_ITEMS / 2) begin
                wait_results_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 20) begin
                op = OP_CHECK;
            end else if (r < (adding_phase ? 75 : 45)) begin
                op = OP_ADD;
            end else if (r < 95) begin
                op = OP_REMOVE;
            end else begin
                op = OP_UNUSED;
            end
            send_request(op, pick_device_id());
        end
        steady_flow = 1'b0;
    endtask

    // Accept result transactions with random stalls (none in steady flow) and compare each one.
    initial begin : result_checker
        int       stall;
        outcome_t want;
        outcome_t got;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid));
            got = m_tdata[$bits(outcome_t)-1:0];
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result was_listed=%0b success=%0b count=%0d",
                         $time, got.was_listed, got.success, got.entry_count);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected was_listed=%0b success=%0b count=%0d",
                             $time, want.was_listed, want.success, want.entry_count);
                    $display("%0t:          actual   was_listed=%0b success=%0b count=%0d",
                             $time, got.was_listed, got.success, got.entry_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_CHECK;
        aresetn  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_fill_to_capacity();
        test_random_traffic();

        // drain, then watch a while longer for stray results
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Stop a hung run well beyond the slowest correct one.
    initial begin : run_limit
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
